/* sv/gcap_pkg.sv */
// Package for the G-code axis command parser: ASCII codes, target codes
// and the control struct passed to the number accumulator. No dependencies.
package gcap_pkg;

    localparam int VALUE_WIDTH_DEFAULT = 16;
    localparam int GOAL_WIDTH          = 16;
    localparam int TARGET_WIDTH        = 3;

    localparam logic [7:0] CH_G       = 8'h47;
    localparam logic [7:0] CH_M       = 8'h4D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_TWO     = 8'h32;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_X       = 8'h58;
    localparam logic [7:0] CH_Y       = 8'h59;
    localparam logic [7:0] CH_Z       = 8'h5A;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [TARGET_WIDTH-1:0] TGT_TILT_SPEED = 3'd0;
    localparam logic [TARGET_WIDTH-1:0] TGT_ZOOM_SPEED = 3'd1;
    localparam logic [TARGET_WIDTH-1:0] TGT_PAN_SPEED  = 3'd2;
    localparam logic [TARGET_WIDTH-1:0] TGT_TILT_ACCEL = 3'd3;
    localparam logic [TARGET_WIDTH-1:0] TGT_PAN_ACCEL  = 3'd4;

    // Control from the line parser to the number accumulator
    typedef struct packed {
        logic clear;
        logic take;
    } number_ctl_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

/* sv/gcap_number.sv */
// Number accumulator of the G-code axis command parser: atol-style
// conversion of digits and a leading minus, wrapping at VALUE_WIDTH bits.
// Depends on gcap_pkg.
module gcap_number #(
    parameter int VALUE_WIDTH = gcap_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  gcap_pkg::number_ctl_t   ctl,
    input  logic [7:0]              rx_byte,
    output logic [VALUE_WIDTH-1:0]  value
);

    logic [VALUE_WIDTH-1:0] accum_reg, accum_next;
    logic                   negative_reg, negative_next;
    logic                   stopped_reg, stopped_next;
    logic                   started_reg, started_next;
    logic [VALUE_WIDTH-1:0] digit_val;

    // Digits 0x30..0x39 carry their value in the low nibble
    assign digit_val = VALUE_WIDTH'(rx_byte[3:0]);

    always_comb
    begin
        accum_next    = accum_reg;
        negative_next = negative_reg;
        stopped_next  = stopped_reg;
        started_next  = started_reg;
        if (ctl.clear)
        begin
            accum_next    = '0;
            negative_next = 1'b0;
            stopped_next  = 1'b0;
            started_next  = 1'b0;
        end
        else if (ctl.take)
        begin
            if (!started_reg)
            begin
                started_next = 1'b1;
                if (rx_byte == gcap_pkg::CH_MINUS)
                    negative_next = 1'b1;
                else
                    accum_next = digit_val;
            end
            else if (!stopped_reg)
            begin
                if (gcap_pkg::is_digit(rx_byte))
                    accum_next = (accum_reg << 3) + (accum_reg << 1) + digit_val;
                else
                    stopped_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg    <= '0;
            negative_reg <= 1'b0;
            stopped_reg  <= 1'b0;
            started_reg  <= 1'b0;
        end
        else
        begin
            accum_reg    <= accum_next;
            negative_reg <= negative_next;
            stopped_reg  <= stopped_next;
            started_reg  <= started_next;
        end
    end

    // Two's complement negate, wrapping
    assign value = negative_reg ? (VALUE_WIDTH'(0) - accum_reg) : accum_reg;

endmodule

/* sv/gcode_axis_command_parser.sv */
// Top level of the G-code axis command parser: line state machine, target
// decode and a two-entry result buffer. Depends on gcap_pkg, gcap_number.
//
// Takes one ASCII byte per transaction and recognizes "G0 <axis><number>\n"
// (speed) and "M201 <axis><number>\n" (acceleration) for axis X, Y or Z. On
// the newline it delivers one result transaction: target (0 tilt speed,
// 1 zoom speed, 2 pan speed, 3 tilt accel, 4 pan accel) and goal_value, the
// number taken as a VALUE_WIDTH-bit two's complement value and sign-extended
// or truncated to 16 bits; the zoom speed keeps only its low 8 bits,
// sign-extended. "M201 Y" lines and any line broken by an unexpected byte
// give no result; an unexpected byte is consumed and returns the parser to
// idle. The state machine and the multiply-by-ten accumulate update in the
// cycle the byte is taken; the result is registered in the output register,
// or in the skid register backing it if that still holds one, so bytes keep
// flowing while a result waits. A byte can be taken every cycle while in_stall
// is low; in_stall rises only when both registers hold a result and the
// downstream side stalls, and falls in the cycle after the output is taken.
module gcode_axis_command_parser #(
    parameter int VALUE_WIDTH = gcap_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [7:0]                             rx_byte,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [gcap_pkg::TARGET_WIDTH-1:0]      target,
    output logic signed [gcap_pkg::GOAL_WIDTH-1:0] goal_value
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_G,
        PH_SPACE,
        PH_AXIS,
        PH_NUMBER,
        PH_M,
        PH_M2,
        PH_M20
    } phase_t;

    phase_t phase_reg, phase_next;
    logic   accel_reg, accel_next;
    logic [1:0] axis_reg, axis_next;

    logic in_accept;
    logic out_take;

    gcap_pkg::number_ctl_t num_ctl;
    logic [VALUE_WIDTH-1:0] num_value;
    logic signed [31:0]     num_ext;

    // Result of the byte being taken this cycle
    logic                                   res_valid;
    logic [gcap_pkg::TARGET_WIDTH-1:0]      res_target;
    logic signed [gcap_pkg::GOAL_WIDTH-1:0] res_goal;

    // Output register and skid register
    logic                                   out_valid_reg;
    logic [gcap_pkg::TARGET_WIDTH-1:0]      out_target_reg;
    logic signed [gcap_pkg::GOAL_WIDTH-1:0] out_goal_reg;
    logic                                   skid_valid_reg;
    logic [gcap_pkg::TARGET_WIDTH-1:0]      skid_target_reg;
    logic signed [gcap_pkg::GOAL_WIDTH-1:0] skid_goal_reg;

    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;

    gcap_number #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_number (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (num_ctl),
        .rx_byte (rx_byte),
        .value   (num_value)
    );

    // Sign-extend the number to 32 bits; the goal takes the low 16
    assign num_ext = 32'(signed'(num_value));

    // Line state machine: advance on an accepted byte, drop to idle on
    // anything unexpected
    always_comb
    begin
        phase_next    = phase_reg;
        accel_next    = accel_reg;
        axis_next     = axis_reg;
        num_ctl.clear = 1'b0;
        num_ctl.take  = 1'b0;
        res_valid     = 1'b0;
        res_target    = gcap_pkg::TGT_TILT_SPEED;
        res_goal      = num_ext[gcap_pkg::GOAL_WIDTH-1:0];
        if (in_accept)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (rx_byte == gcap_pkg::CH_G)
                        phase_next = PH_G;
                    else if (rx_byte == gcap_pkg::CH_M)
                        phase_next = PH_M;
                end
                PH_G:
                begin
                    if (rx_byte == gcap_pkg::CH_ZERO)
                    begin
                        accel_next = 1'b0;
                        phase_next = PH_SPACE;
                    end
                    else
                        phase_next = PH_IDLE;
                end
                PH_SPACE:
                    phase_next = (rx_byte == gcap_pkg::CH_SPACE) ? PH_AXIS : PH_IDLE;
                PH_AXIS:
                begin
                    if (rx_byte == gcap_pkg::CH_X || rx_byte == gcap_pkg::CH_Y
                        || rx_byte == gcap_pkg::CH_Z)
                    begin
                        // 'X', 'Y', 'Z' differ from 'X' in the two low bits
                        axis_next     = rx_byte[1:0];
                        num_ctl.clear = 1'b1;
                        phase_next    = PH_NUMBER;
                    end
                    else
                        phase_next = PH_IDLE;
                end
                PH_NUMBER:
                begin
                    if (rx_byte == gcap_pkg::CH_NEWLINE)
                    begin
                        num_ctl.clear = 1'b1;
                        phase_next    = PH_IDLE;
                        // Decode the target; M201 Y has none
                        priority case (1'b1)
                            !accel_reg && axis_reg == gcap_pkg::AXIS_X:
                            begin
                                res_valid  = 1'b1;
                                res_target = gcap_pkg::TGT_TILT_SPEED;
                            end
                            !accel_reg && axis_reg == gcap_pkg::AXIS_Y:
                            begin
                                res_valid  = 1'b1;
                                res_target = gcap_pkg::TGT_ZOOM_SPEED;
                                res_goal   = {{8{num_ext[7]}}, num_ext[7:0]};
                            end
                            !accel_reg && axis_reg == gcap_pkg::AXIS_Z:
                            begin
                                res_valid  = 1'b1;
                                res_target = gcap_pkg::TGT_PAN_SPEED;
                            end
                            accel_reg && axis_reg == gcap_pkg::AXIS_X:
                            begin
                                res_valid  = 1'b1;
                                res_target = gcap_pkg::TGT_TILT_ACCEL;
                            end
                            accel_reg && axis_reg == gcap_pkg::AXIS_Z:
                            begin
                                res_valid  = 1'b1;
                                res_target = gcap_pkg::TGT_PAN_ACCEL;
                            end
                            default:
                                res_valid = 1'b0;
                        endcase
                    end
                    else if (gcap_pkg::is_digit(rx_byte) || rx_byte == gcap_pkg::CH_MINUS)
                        num_ctl.take = 1'b1;
                    else
                    begin
                        num_ctl.clear = 1'b1;
                        phase_next    = PH_IDLE;
                    end
                end
                PH_M:
                    phase_next = (rx_byte == gcap_pkg::CH_TWO) ? PH_M2 : PH_IDLE;
                PH_M2:
                    phase_next = (rx_byte == gcap_pkg::CH_ZERO) ? PH_M20 : PH_IDLE;
                PH_M20:
                begin
                    if (rx_byte == gcap_pkg::CH_ONE)
                    begin
                        accel_next = 1'b1;
                        phase_next = PH_SPACE;
                    end
                    else
                        phase_next = PH_IDLE;
                end
                default:
                    phase_next = PH_IDLE;
            endcase
        end
    end

    // State and the two-entry result buffer. The skid register fills only
    // when the output register holds a result that is not taken; while it
    // is full no byte is accepted, so no new result can arrive.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            accel_reg      <= 1'b0;
            axis_reg       <= gcap_pkg::AXIS_X;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            accel_reg <= accel_next;
            axis_reg  <= axis_next;
            if (skid_valid_reg)
            begin
                if (out_take)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (!out_valid_reg || out_take)
                out_valid_reg <= res_valid;
            else if (res_valid)
                skid_valid_reg <= 1'b1;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_target_reg <= skid_target_reg;
                out_goal_reg   <= skid_goal_reg;
            end
        end
        else if (!out_valid_reg || out_take)
        begin
            if (res_valid)
            begin
                out_target_reg <= res_target;
                out_goal_reg   <= res_goal;
            end
        end
        else if (res_valid)
        begin
            skid_target_reg <= res_target;
            skid_goal_reg   <= res_goal;
        end
    end

    assign out_valid  = out_valid_reg;
    assign target     = out_target_reg;
    assign goal_value = out_goal_reg;

    // The skid register never holds a result ahead of an empty output
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    // A result comes only from a newline taken in the number phase
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (in_accept && phase_reg == PH_NUMBER
                       && rx_byte == gcap_pkg::CH_NEWLINE))
        else $error("result produced outside a newline in the number phase");

    // Only the five defined targets are ever delivered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_target_reg <= gcap_pkg::TGT_PAN_ACCEL))
        else $error("undefined target code delivered");

    // Zoom speed goals are 8-bit values sign-extended
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_target_reg == gcap_pkg::TGT_ZOOM_SPEED)
        |-> (out_goal_reg[15:8] == {8{out_goal_reg[7]}}))
        else $error("zoom speed goal not sign-extended from 8 bits");

    // A result arriving with the output stalled lands in the skid register
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && out_valid_reg && out_stall) |=> skid_valid_reg)
        else $error("result lost while output stalled");

endmodule

/* verif/gcap_update_checker.sv */
`timescale 1ns / 1ps
// Update checker for the G-code axis command parser: predicts each goal
// update from the accepted bytes and compares it with the result channel.
// Depends on gcap_pkg.
module gcap_update_checker #(
    parameter int VALUE_WIDTH = gcap_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic                                   in_stall,
    input  logic [7:0]                             rx_byte,
    input  logic                                   out_valid,
    input  logic                                   out_stall,
    input  logic [gcap_pkg::TARGET_WIDTH-1:0]      target,
    input  logic signed [gcap_pkg::GOAL_WIDTH-1:0] goal_value,
    output int                                     fail_count,
    output int                                     pending_updates
);

    typedef enum logic [3:0] {
        LINE_IDLE,
        LINE_G,
        LINE_SPACE,
        LINE_AXIS,
        LINE_NUMBER,
        LINE_M,
        LINE_M2,
        LINE_M20
    } line_phase_t;

    typedef struct packed {
        logic [gcap_pkg::TARGET_WIDTH-1:0]      tgt;
        logic signed [gcap_pkg::GOAL_WIDTH-1:0] goal;
    } goal_update_t;

    line_phase_t            line_phase;
    logic                   accel_cmd;
    logic [1:0]             axis;
    logic [VALUE_WIDTH-1:0] num_mag;
    logic                   num_negative;
    logic                   num_stopped;
    logic                   num_started;

    goal_update_t expected_updates[$];
    int           errors;

    task automatic clear_number();
        num_mag      = '0;
        num_negative = 1'b0;
        num_stopped  = 1'b0;
        num_started  = 1'b0;
    endtask

    // Advance the line parser by one byte; report the update it causes, if any
    task automatic advance_parser(input logic [7:0] b, output bit emits,
                                  output goal_update_t upd);
        logic [VALUE_WIDTH-1:0] twos;
        logic signed [63:0]     wide;
        logic                   digit;
        emits = 1'b0;
        upd   = '0;
        digit = (b >= gcap_pkg::CH_ZERO) && (b <= gcap_pkg::CH_NINE);
        case (line_phase)
            LINE_IDLE:
            begin
                if (b == gcap_pkg::CH_G)
                    line_phase = LINE_G;
                else if (b == gcap_pkg::CH_M)
                    line_phase = LINE_M;
                else
                    line_phase = LINE_IDLE;
            end
            LINE_G:
            begin
                if (b == gcap_pkg::CH_ZERO)
                begin
                    accel_cmd  = 1'b0;
                    line_phase = LINE_SPACE;
                end
                else
                    line_phase = LINE_IDLE;
            end
            LINE_SPACE:
                line_phase = (b == gcap_pkg::CH_SPACE) ? LINE_AXIS : LINE_IDLE;
            LINE_AXIS:
            begin
                if (b == gcap_pkg::CH_X || b == gcap_pkg::CH_Y || b == gcap_pkg::CH_Z)
                begin
                    axis = 2'(b - gcap_pkg::CH_X);
                    clear_number();
                    line_phase = LINE_NUMBER;
                end
                else
                    line_phase = LINE_IDLE;
            end
            LINE_NUMBER:
            begin
                if (b == gcap_pkg::CH_NEWLINE)
                begin
                    twos     = num_negative ? -num_mag : num_mag;
                    wide     = 64'(signed'(twos));
                    upd.goal = wide[gcap_pkg::GOAL_WIDTH-1:0];
                    emits    = 1'b1;
                    if (!accel_cmd)
                    begin
                        case (axis)
                            gcap_pkg::AXIS_X: upd.tgt = gcap_pkg::TGT_TILT_SPEED;
                            gcap_pkg::AXIS_Y:
                            begin
                                upd.tgt  = gcap_pkg::TGT_ZOOM_SPEED;
                                upd.goal = {{(gcap_pkg::GOAL_WIDTH-8){wide[7]}}, wide[7:0]};
                            end
                            default: upd.tgt = gcap_pkg::TGT_PAN_SPEED;
                        endcase
                    end
                    else if (axis == gcap_pkg::AXIS_X)
                        upd.tgt = gcap_pkg::TGT_TILT_ACCEL;
                    else if (axis == gcap_pkg::AXIS_Z)
                        upd.tgt = gcap_pkg::TGT_PAN_ACCEL;
                    else
                        emits = 1'b0;
                    clear_number();
                    line_phase = LINE_IDLE;
                end
                else if (digit || b == gcap_pkg::CH_MINUS)
                begin
                    if (!num_started)
                    begin
                        num_started = 1'b1;
                        if (b == gcap_pkg::CH_MINUS)
                            num_negative = 1'b1;
                        else
                            num_mag = VALUE_WIDTH'(b - gcap_pkg::CH_ZERO);
                    end
                    else if (!num_stopped)
                    begin
                        if (digit)
                            num_mag = VALUE_WIDTH'(num_mag * 10 + (b - gcap_pkg::CH_ZERO));
                        else
                            num_stopped = 1'b1;
                    end
                end
                else
                begin
                    clear_number();
                    line_phase = LINE_IDLE;
                end
            end
            LINE_M:
                line_phase = (b == gcap_pkg::CH_TWO) ? LINE_M2 : LINE_IDLE;
            LINE_M2:
                line_phase = (b == gcap_pkg::CH_ZERO) ? LINE_M20 : LINE_IDLE;
            LINE_M20:
            begin
                if (b == gcap_pkg::CH_ONE)
                begin
                    accel_cmd  = 1'b1;
                    line_phase = LINE_SPACE;
                end
                else
                    line_phase = LINE_IDLE;
            end
            default:
                line_phase = LINE_IDLE;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        bit           emits;
        goal_update_t upd;
        goal_update_t want;
        if (!rst_n)
        begin
            line_phase = LINE_IDLE;
            accel_cmd  = 1'b0;
            axis       = gcap_pkg::AXIS_X;
            clear_number();
            expected_updates.delete();
            errors = 0;
            fail_count      <= 0;
            pending_updates <= 0;
        end
        else
        begin
            // Results leave before this edge's byte can cause one
            if (out_valid && !out_stall)
            begin
                if (expected_updates.size() == 0)
                begin
                    $error("unexpected result: target %0d goal_value %0d", target, goal_value);
                    errors++;
                end
                else
                begin
                    want = expected_updates.pop_front();
                    if (target !== want.tgt)
                    begin
                        $error("target: expected %0d, actual %0d", want.tgt, target);
                        errors++;
                    end
                    if (goal_value !== want.goal)
                    begin
                        $error("goal_value: expected %0d, actual %0d", want.goal, goal_value);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                advance_parser(rx_byte, emits, upd);
                if (emits)
                    expected_updates.push_back(upd);
            end
            fail_count      <= errors;
            pending_updates <= expected_updates.size();
        end
    end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top for the G-code axis command parser: clock, reset, byte
// stimulus and result-side stalls; the verdict comes from gcap_update_checker.
// Depends on gcap_pkg and gcode_axis_command_parser.
module tb_top;

    localparam int RANDOM_ITEMS     = 1400;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES     = 16;

    logic                                   clk;
    logic                                   rst_n      = 1'b0;
    logic                                   in_valid   = 1'b0;
    logic                                   in_stall;
    logic [7:0]                             rx_byte    = 8'h00;
    logic                                   out_valid;
    logic                                   out_stall  = 1'b0;
    logic [gcap_pkg::TARGET_WIDTH-1:0]      target;
    logic signed [gcap_pkg::GOAL_WIDTH-1:0] goal_value;

    int fail_count;
    int pending_updates;

    // Idle and stall rates in percent, changed per phase by the stimulus
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int bytes_sent    = 0;

    // Long hold-off requests: the stimulus bumps the request count, the
    // receiver serves each one as a stretch of stalled cycles
    int hold_requests = 0;
    int hold_served   = 0;

    gcode_axis_command_parser dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .target     (target),
        .goal_value (goal_value)
    );

    gcap_update_checker update_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .target          (target),
        .goal_value      (goal_value),
        .fail_count      (fail_count),
        .pending_updates (pending_updates)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop well beyond the slowest correct run
    initial
    begin
        #400000;
        $display("FAIL");
        $finish;
    end

    // Result side: random stalls, or a long hold when one is requested
    initial
    begin : receiver
        int stretch;
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                stretch = 0;
                while (stretch < LONG_HOLD_CYCLES)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                    stretch++;
                end
            end
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Offer one byte, idle first at the phase's rate, and hold it until the
    // transaction completes. Valid stays high on return so back-to-back
    // bytes do not see valid dropped and raised in one step.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_string(input string s);
        foreach (s[i])
            send_byte(s[i]);
    endtask

    // Build one command line with random prefix, axis and number; when
    // break_it is set, corrupt one byte or cut the line short
    task automatic send_command_line(input bit break_it);
        logic [7:0] text[$];
        int         n_digits;
        int         cut;
        if ($urandom_range(0, 1))
            text = '{gcap_pkg::CH_G, gcap_pkg::CH_ZERO, gcap_pkg::CH_SPACE};
        else
            text = '{gcap_pkg::CH_M, gcap_pkg::CH_TWO, gcap_pkg::CH_ZERO,
                     gcap_pkg::CH_ONE, gcap_pkg::CH_SPACE};
        case ($urandom_range(0, 2))
            0: text.push_back(gcap_pkg::CH_X);
            1: text.push_back(gcap_pkg::CH_Y);
            default: text.push_back(gcap_pkg::CH_Z);
        endcase
        if ($urandom_range(0, 99) < 35)
            text.push_back(gcap_pkg::CH_MINUS);
        // Mostly short numbers; now and then long enough to wrap
        n_digits = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 9) : $urandom_range(0, 5);
        for (int i = 0; i < n_digits; i++)
        begin
            text.push_back(8'(gcap_pkg::CH_ZERO + $urandom_range(0, 9)));
            // A stray minus inside the number stops the conversion
            if ($urandom_range(0, 19) == 0)
                text.push_back(gcap_pkg::CH_MINUS);
        end
        text.push_back(gcap_pkg::CH_NEWLINE);
        if (break_it)
        begin
            cut = $urandom_range(0, text.size() - 1);
            if ($urandom_range(0, 1))
                text[cut] = 8'($urandom_range(0, 255));
            else
                text = text[0:cut];
        end
        foreach (text[i])
            send_byte(text[i]);
    endtask

    initial
    begin : stimulus
        int pick;
        int burst;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zoom speed at its negative extreme, the silent M201 Y
        // line, a lone minus, and the byte extremes as noise
        send_string("G0 Y-128\n");
        send_string("M201 Y7\n");
        send_string("M201 Z-\n");
        send_byte(8'hFF);
        send_byte(8'h00);

        // Hold the result side off while bytes keep coming, so the
        // result buffer fills and the input stalls
        hold_requests++;

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 59; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 59; end
                default: begin send_idle_pct = 35; stall_pct = 35; end
            endcase
            while (bytes_sent < (phase + 1) * RANDOM_ITEMS / 4)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    send_command_line(1'b0);
                else if (pick < 90)
                    send_command_line(1'b1);
                else
                begin
                    burst = $urandom_range(1, 3);
                    repeat (burst)
                        send_byte(8'($urandom_range(0, 255)));
                end
            end
        end
        in_valid <= 1'b0;

        // Drain: wait for every predicted update, then a few more cycles
        // to catch anything extra
        @(posedge clk);
        while (pending_updates != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
